FILE: hdl/ring_send_buffer_allocator_assert.svh
// assertion macros for the ring send buffer allocator checker
// no dependencies; included by rsba_checker, which holds the concurrent assertions
`ifndef RING_SEND_BUFFER_ALLOCATOR_ASSERT_SVH
`define RING_SEND_BUFFER_ALLOCATOR_ASSERT_SVH

// same-cycle implication under the active low reset
`define RSBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the active low reset
`define RSBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rsba_pkg.sv
// types and constants of the ring send buffer allocator
// no dependencies; imported by every module but rsba_ram
`default_nettype none

package rsba_pkg;

	localparam int CAP_W    = 21;
	localparam int OFF_W    = 20;
	localparam int CID_W    = 12;
	localparam int SIZE_W   = 21;
	localparam int STATUS_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);

	typedef enum logic [1:0] {
		MODE_ALLOC    = 2'd0,
		MODE_SUBMIT   = 2'd1,
		MODE_COMPLETE = 2'd2,
		MODE_CANCEL   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_BAD_SIZE    = 3'd1,
		ST_RING_FULL   = 3'd2,
		ST_ORDER_FULL  = 3'd3,
		ST_UNKNOWN_CID = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_MARK_WR,
		S_WALK_RD,
		S_WALK_CHK,
		S_ALLOC_CALC,
		S_ALLOC_COMMIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		mode_t             mode;
		logic [SIZE_W-1:0] size;
		logic [CID_W-1:0]  cid;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [OFF_W-1:0]  offset;
		logic [SIZE_W-1:0] granted_length;
		logic [CAP_W-1:0]  free_bytes;
	} rsp_t;

	// finished result handed from the core to the output register
	typedef struct packed {
		logic valid;
		rsp_t data;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/rsba_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module rsba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/rsba_core.sv
// sequencer of the allocator: ring pointers, order buffer and cid map
// depends on rsba_pkg and rsba_ram
`default_nettype none

module rsba_core #(
	parameter int MAX_BYTES     = 1048576,
	parameter int ORDER_ENTRIES = 256,
	parameter int CID_COUNT     = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  rsba_pkg::req_t             req,
	output rsba_pkg::res_t             res,
	input  logic                       res_take,
	input  logic                       cap_we,
	input  logic [rsba_pkg::CAP_W-1:0] cap_wdata
);

	import rsba_pkg::*;

	localparam int OW  = $clog2(ORDER_ENTRIES);
	localparam int CW  = $clog2(ORDER_ENTRIES + 1);
	localparam int CIW = $clog2(CID_COUNT);
	// order entry: charged length, submitted mark, completed mark
	localparam int EW  = CAP_W + 2;
	// cid map entry: known flag and order entry index
	localparam int MW  = OW + 1;

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] tail_q, tail_d;
	logic [CAP_W-1:0] used_q, used_d;
	logic [OW-1:0]    head_q, head_d;
	logic [OW-1:0]    otail_q, otail_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CIW-1:0]   clr_q, clr_d;

	req_t             req_q, req_d;
	logic [OW-1:0]    ent_q, ent_d;
	logic [CAP_W-1:0] start_q, start_d;
	logic [CAP_W:0]   charge_q, charge_d;
	status_t          status_q, status_d;

	logic             ent_we, ent_re;
	logic [OW-1:0]    ent_waddr, ent_raddr;
	logic [EW-1:0]    ent_wdata, ent_rdata;
	logic             map_we, map_re;
	logic [CIW-1:0]   map_waddr, map_raddr;
	logic [MW-1:0]    map_wdata, map_rdata;

	logic [CAP_W-1:0] eff_cap;
	logic             cid_ok;
	logic             is_alloc;
	logic             accept;

	function automatic logic [OW-1:0] next_idx(input logic [OW-1:0] idx);
		return (idx == OW'(ORDER_ENTRIES - 1)) ? '0 : idx + 1'b1;
	endfunction

	assign eff_cap  = (32'(cap_q) > 32'(MAX_BYTES)) ? CAP_W'(MAX_BYTES) : cap_q;
	assign cid_ok   = 32'(req_q.cid) < 32'(CID_COUNT);
	assign is_alloc = req_q.mode == MODE_ALLOC;
	assign accept   = req_valid && !req_stall;

	assign req_stall = state_q != S_IDLE;

	rsba_ram #(
		.WIDTH(EW),
		.DEPTH(ORDER_ENTRIES)
	) u_order_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	rsba_ram #(
		.WIDTH(MW),
		.DEPTH(CID_COUNT)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (map_re),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	always_comb begin
		logic              bad_size;
		logic [CAP_W:0]    tail_sum;
		logic [CAP_W-1:0]  pad;
		logic [CAP_W+1:0]  need;
		logic [CAP_W:0]    next_tail;
		logic [CAP_W-1:0]  len;
		logic              walk_done;

		state_d   = state_q;
		tail_d    = tail_q;
		used_d    = used_q;
		head_d    = head_q;
		otail_d   = otail_q;
		count_d   = count_q;
		clr_d     = clr_q;
		req_d     = req_q;
		ent_d     = ent_q;
		start_d   = start_q;
		charge_d  = charge_q;
		status_d  = status_q;

		ent_we    = 1'b0;
		ent_re    = 1'b0;
		ent_waddr = ent_q;
		ent_raddr = head_q;
		ent_wdata = ent_rdata;
		map_we    = 1'b0;
		map_re    = 1'b0;
		map_waddr = clr_q;
		map_raddr = CIW'(req.cid);
		map_wdata = '0;

		bad_size  = (req_q.size == '0) || (req_q.size[1:0] != 2'b00) ||
			(req_q.size > eff_cap);
		tail_sum  = (CAP_W+1)'(tail_q) + (CAP_W+1)'(req_q.size);
		pad       = (tail_q < eff_cap) ? eff_cap - tail_q : '0;
		need      = (CAP_W+2)'(used_q) + (CAP_W+2)'(charge_q);
		next_tail = (CAP_W+1)'(start_q) + (CAP_W+1)'(req_q.size);
		len       = ent_rdata[EW-1:2];
		walk_done = 1'b0;

		res.valid               = 1'b0;
		res.data.status         = status_q;
		res.data.offset         = ((status_q == ST_OK) && is_alloc) ? OFF_W'(start_q) : '0;
		res.data.granted_length = ((status_q == ST_OK) && is_alloc) ? req_q.size : '0;
		res.data.free_bytes     = (used_q > eff_cap) ? '0 : eff_cap - used_q;

		case (state_q)
			S_CLEAR: begin
				// every cid starts unknown
				map_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == CIW'(CID_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					req_d   = req;
					map_re  = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (is_alloc) begin
					if (bad_size) begin
						status_d = ST_BAD_SIZE;
						state_d  = S_FINISH;
					end else begin
						state_d = S_WALK_RD;
					end
				end else if (!cid_ok || !map_rdata[MW-1]) begin
					status_d = ST_UNKNOWN_CID;
					state_d  = S_FINISH;
				end else begin
					ent_re    = 1'b1;
					ent_raddr = map_rdata[OW-1:0];
					ent_d     = map_rdata[OW-1:0];
					state_d   = S_MARK_WR;
				end
			end
			S_MARK_WR: begin
				ent_we       = 1'b1;
				ent_wdata[1] = ent_rdata[1] || (req_q.mode inside {MODE_SUBMIT, MODE_CANCEL});
				ent_wdata[0] = ent_rdata[0] || (req_q.mode inside {MODE_COMPLETE, MODE_CANCEL});
				state_d      = S_WALK_RD;
			end
			S_WALK_RD: begin
				if (count_q == '0) begin
					walk_done = 1'b1;
				end else begin
					ent_re  = 1'b1;
					state_d = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				if (ent_rdata[1] && ent_rdata[0]) begin
					used_d  = (len > used_q) ? '0 : used_q - len;
					head_d  = next_idx(head_q);
					count_d = count_q - 1'b1;
					state_d = S_WALK_RD;
				end else begin
					walk_done = 1'b1;
				end
			end
			S_ALLOC_CALC: begin
				// skip the tail padding when the request runs past the end
				if (tail_sum > (CAP_W+1)'(eff_cap)) begin
					start_d  = '0;
					charge_d = (CAP_W+1)'(req_q.size) + (CAP_W+1)'(pad);
				end else begin
					start_d  = tail_q;
					charge_d = (CAP_W+1)'(req_q.size);
				end
				state_d = S_ALLOC_COMMIT;
			end
			S_ALLOC_COMMIT: begin
				state_d = S_FINISH;
				if (need > (CAP_W+2)'(eff_cap)) begin
					status_d = ST_RING_FULL;
				end else if (count_q == CW'(ORDER_ENTRIES)) begin
					status_d = ST_ORDER_FULL;
				end else begin
					status_d  = ST_OK;
					used_d    = CAP_W'(need);
					tail_d    = (next_tail >= (CAP_W+1)'(eff_cap)) ? '0 : CAP_W'(next_tail);
					ent_we    = 1'b1;
					ent_waddr = otail_q;
					ent_wdata = {CAP_W'(charge_q), 2'b00};
					map_we    = cid_ok;
					map_waddr = CIW'(req_q.cid);
					map_wdata = {1'b1, otail_q};
					otail_d   = next_idx(otail_q);
					count_d   = count_q + 1'b1;
				end
			end
			S_FINISH: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (walk_done) begin
			if (is_alloc) begin
				state_d = S_ALLOC_CALC;
			end else begin
				status_d = ST_OK;
				state_d  = S_FINISH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			tail_q  <= '0;
			used_q  <= '0;
			head_q  <= '0;
			otail_q <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			tail_q  <= tail_d;
			used_q  <= used_d;
			head_q  <= head_d;
			otail_q <= otail_d;
			count_q <= count_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		ent_q    <= ent_d;
		start_q  <= start_d;
		charge_q <= charge_d;
		status_q <= status_d;
	end

endmodule

`default_nettype wire

FILE: hdl/ring_send_buffer_allocator.sv
// Byte ring allocator with in-order reclaim. One request is worked at a time; the
// response sits in an output register so the next request can be taken while it
// waits. A bad size or an unknown cid goes from decode straight to the response;
// submit, complete or cancel first marks its order entry. Then the reclaim walk
// frees fully marked entries from the head, reading one entry at a time through the
// single read port of the order memory, and an allocate goes on to reckon and commit
// its grant. After reset the cid map is swept clear, during which req_stall is held
// high; capacity writes are taken at any time.
// depends on rsba_pkg and rsba_core
`default_nettype none

module ring_send_buffer_allocator #(
	parameter int MAX_BYTES     = 1048576,
	parameter int ORDER_ENTRIES = 256,
	parameter int CID_COUNT     = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  rsba_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output rsba_pkg::rsp_t             rsp,
	input  logic                       cap_we,
	input  logic [rsba_pkg::CAP_W-1:0] cap_wdata
);

	import rsba_pkg::*;

	res_t res;
	logic res_take;
	logic rsp_valid_q;
	rsp_t rsp_q;

	rsba_core #(
		.MAX_BYTES    (MAX_BYTES),
		.ORDER_ENTRIES(ORDER_ENTRIES),
		.CID_COUNT    (CID_COUNT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res      (res),
		.res_take (res_take),
		.cap_we   (cap_we),
		.cap_wdata(cap_wdata)
	);

	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			rsp_q <= res.data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: hdl/rsba_checker.sv
// port-level checks of the ring send buffer allocator, bound to the top level
// depends on rsba_pkg and ring_send_buffer_allocator_assert.svh
`default_nettype none

`include "ring_send_buffer_allocator_assert.svh"

module rsba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input rsba_pkg::rsp_t rsp
);

	import rsba_pkg::*;

	`RSBA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

	// one request in flight: stall rises right after a request is taken
	`RSBA_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall, "request taken while busy")

	`RSBA_ASSERT_IMP(a_fail_no_grant, clk, arst_n, rsp_valid && rsp.status != ST_OK, rsp.offset == '0 && rsp.granted_length == '0, "failed request carries a grant")

	`RSBA_ASSERT_IMP(a_grant_aligned, clk, arst_n, rsp_valid && rsp.granted_length != '0, rsp.status == ST_OK && rsp.granted_length[1:0] == 2'b00, "grant not word aligned")

endmodule

bind ring_send_buffer_allocator rsba_checker u_rsba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire

FILE: bench/rsba_grant_check.sv
`timescale 1ns / 1ps
// scoreboard for the ring send buffer allocator: follows the request, response and capacity
// ports, predicts every response and compares it field by field; depends on rsba_pkg

module rsba_grant_check
	import rsba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp,
	input  logic             cap_we,
	input  logic [CAP_W-1:0] cap_wdata,
	output int               fails,
	output int               awaiting
);

	localparam int MAX_BYTES     = 1048576;
	localparam int ORDER_ENTRIES = 256;
	localparam int CID_COUNT     = 4096;

	logic [CAP_W-1:0] cap_reg;
	logic [OFF_W-1:0] ring_tail;
	logic [CAP_W-1:0] used;
	logic [7:0]       head_slot;
	logic [7:0]       tail_slot;
	logic [8:0]       open_count;
	logic [CAP_W-1:0] slot_len  [ORDER_ENTRIES];
	logic             slot_sub  [ORDER_ENTRIES];
	logic             slot_done [ORDER_ENTRIES];
	logic [7:0]       cid_slot  [CID_COUNT];
	logic             cid_live  [CID_COUNT];
	rsp_t             grants_due [$];
	rsp_t             want;
	rsp_t             predicted;
	int               j;

	function automatic logic [CAP_W-1:0] eff_cap();
		return (cap_reg > CAP_W'(MAX_BYTES)) ? CAP_W'(MAX_BYTES) : cap_reg;
	endfunction

	// free fully marked entries from the head, oldest first
	task automatic reclaim_head();
		logic [CAP_W-1:0] len;
		while (open_count != 9'd0 && slot_sub[head_slot] && slot_done[head_slot]) begin
			len        = slot_len[head_slot];
			used       = (len > used) ? '0 : used - len;
			head_slot  = head_slot + 8'd1;
			open_count = open_count - 9'd1;
		end
	endtask

	task automatic serve_request(input req_t r, output rsp_t o);
		logic [CAP_W-1:0] cap;
		logic [CAP_W+1:0] reach;
		logic [CAP_W+1:0] pad;
		logic [CAP_W+1:0] charge;
		logic [CAP_W+1:0] next_tail;
		logic [OFF_W-1:0] start;
		logic [7:0]       e;
		cap      = eff_cap();
		o        = '0;
		o.status = ST_OK;
		if (r.mode == MODE_ALLOC) begin
			if (r.size == '0 || r.size[1:0] != 2'b00 || r.size > cap) begin
				o.status = ST_BAD_SIZE;
			end else begin
				reclaim_head();
				reach = (CAP_W+2)'(ring_tail) + (CAP_W+2)'(r.size);
				if (reach > (CAP_W+2)'(cap)) begin
					// skip the tail padding and start again at offset 0
					pad    = (CAP_W'(ring_tail) < cap) ?
						(CAP_W+2)'(cap) - (CAP_W+2)'(ring_tail) : '0;
					start  = '0;
					charge = (CAP_W+2)'(r.size) + pad;
				end else begin
					start  = ring_tail;
					charge = (CAP_W+2)'(r.size);
				end
				if ({2'b00, used} + charge > {2'b00, cap}) begin
					o.status = ST_RING_FULL;
				end else if (open_count >= 9'(ORDER_ENTRIES)) begin
					o.status = ST_ORDER_FULL;
				end else begin
					used      = used + charge[CAP_W-1:0];
					next_tail = (CAP_W+2)'(start) + (CAP_W+2)'(r.size);
					ring_tail = (next_tail >= (CAP_W+2)'(cap)) ? '0 : next_tail[OFF_W-1:0];
					slot_len[tail_slot]  = charge[CAP_W-1:0];
					slot_sub[tail_slot]  = 1'b0;
					slot_done[tail_slot] = 1'b0;
					cid_slot[r.cid]      = tail_slot;
					cid_live[r.cid]      = 1'b1;
					tail_slot  = tail_slot + 8'd1;
					open_count = open_count + 9'd1;
					o.offset         = start;
					o.granted_length = r.size;
				end
			end
		end else begin
			if (!cid_live[r.cid]) begin
				o.status = ST_UNKNOWN_CID;
			end else begin
				// a stale cid still marks the slot it last held
				e = cid_slot[r.cid];
				if (r.mode == MODE_SUBMIT || r.mode == MODE_CANCEL)
					slot_sub[e] = 1'b1;
				if (r.mode == MODE_COMPLETE || r.mode == MODE_CANCEL)
					slot_done[e] = 1'b1;
				reclaim_head();
			end
		end
		o.free_bytes = (used > cap) ? '0 : cap - used;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg    = CAP_RESET;
			ring_tail  = '0;
			used       = '0;
			head_slot  = '0;
			tail_slot  = '0;
			open_count = '0;
			for (j = 0; j < ORDER_ENTRIES; j++) begin
				slot_sub[j]  = 1'b0;
				slot_done[j] = 1'b0;
			end
			for (j = 0; j < CID_COUNT; j++)
				cid_live[j] = 1'b0;
			grants_due.delete();
			fails = 0;
			awaiting <= 0;
		end else begin
			if (cap_we)
				cap_reg = cap_wdata;
			if (rsp_valid && !rsp_stall) begin
				if (grants_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("response with no request outstanding: st=%0d off=%0d len=%0d free=%0d",
							rsp.status, rsp.offset, rsp.granted_length, rsp.free_bytes);
				end else begin
					want = grants_due.pop_front();
					if (rsp.status !== want.status || rsp.offset !== want.offset ||
							rsp.granted_length !== want.granted_length ||
							rsp.free_bytes !== want.free_bytes) begin
						fails++;
						if (fails <= 10)
							$display("want st=%0d off=%0d len=%0d free=%0d, got st=%0d off=%0d len=%0d free=%0d",
								want.status, want.offset, want.granted_length, want.free_bytes,
								rsp.status, rsp.offset, rsp.granted_length, rsp.free_bytes);
					end
				end
			end
			if (req_valid && !req_stall) begin
				serve_request(req, predicted);
				grants_due.push_back(predicted);
			end
			awaiting <= awaiting + int'(req_valid && !req_stall) - int'(rsp_valid && !rsp_stall);
		end
	end

endmodule

FILE: bench/tb_ring_send_buffer_allocator.sv
`timescale 1ns / 1ps
// top of the ring send buffer allocator bench: clock, reset, request and capacity stimulus,
// response back-pressure and the verdict; depends on rsba_pkg, rsba_grant_check and the dut

module tb_ring_send_buffer_allocator;
	import rsba_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cap_we    = 1'b0;
	logic [CAP_W-1:0] cap_wdata = '0;
	int               fails;
	int               awaiting;

	int               cap_now    = 65536;
	int               quiet_left = 0;
	bit               rx_hold    = 1'b0;
	logic [CID_W-1:0] open_cids [$];
	bit               cid_open [1 << CID_W];

	always #6 clk = ~clk;

	ring_send_buffer_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cap_we    (cap_we),
		.cap_wdata (cap_wdata)
	);

	rsba_grant_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cap_we    (cap_we),
		.cap_wdata (cap_wdata),
		.fails     (fails),
		.awaiting  (awaiting)
	);

	initial begin
		#100_000_000;
		$display("ring_send_buffer_allocator: mismatch");
		$finish;
	end

	// response side: random back-pressure, plus one long hold when asked
	initial begin : rx_side
		int n;
		int r;
		bit v;
		forever begin
			if (rx_hold) begin
				@(posedge clk);
				rsp_stall <= 1'b1;
				for (n = 1; n < 400; n++)
					@(posedge clk);
				rx_hold = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					v = 1'b0;
					n = $urandom_range(1, 12);
				end else if (r < 60) begin
					v = 1'b0;
					n = $urandom_range(20, 80);
				end else if (r < 92) begin
					v = 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					v = 1'b1;
					n = $urandom_range(5, 40);
				end
				repeat (n) begin
					@(posedge clk);
					rsp_stall <= v;
				end
			end
		end
	end

	// offer one request, hold it until taken, then idle for a random gap that may be zero
	task automatic drive_req(input mode_t m, input logic [SIZE_W-1:0] sz,
			input logic [CID_W-1:0] id);
		int gap;
		int r;
		req       <= '{mode: m, size: sz, cid: id};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (quiet_left > 0) begin
			quiet_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// allocate under a cid that no open allocation holds, so no entry is orphaned
	task automatic alloc_fresh(input logic [SIZE_W-1:0] sz);
		logic [CID_W-1:0] id;
		id = CID_W'($urandom);
		while (cid_open[id])
			id = CID_W'($urandom);
		cid_open[id] = 1'b1;
		open_cids.push_back(id);
		drive_req(MODE_ALLOC, sz, id);
	endtask

	task automatic cancel_front();
		logic [CID_W-1:0] id;
		id = open_cids.pop_front();
		cid_open[id] = 1'b0;
		drive_req(MODE_CANCEL, SIZE_W'($urandom), id);
	endtask

	task automatic drain_open();
		while (open_cids.size() != 0)
			cancel_front();
	endtask

	// stop offering until every response is back
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_cap(input int v);
		settle();
		cap_we    <= 1'b1;
		cap_wdata <= CAP_W'(v);
		@(posedge clk);
		cap_we    <= 1'b0;
		cap_now = (v > 1048576) ? 1048576 : v;
	endtask

	task automatic random_phase(input int count, input bit squeeze);
		int               i;
		int               r;
		int               k;
		int               q;
		logic [SIZE_W-1:0] sz;
		mode_t            m;
		logic [CID_W-1:0] id;
		for (i = 0; i < count; i++) begin
			if (squeeze && i == 40) begin
				// long receiver hold while requests keep coming back to back
				rx_hold    = 1'b1;
				quiet_left = 48;
			end
			if (i == count / 2)
				settle();
			if ($urandom_range(0, 49) == 0)
				quiet_left = 30;
			r = $urandom_range(0, 99);
			q = cap_now / 4;
			if (r < 8) begin
				m = mode_t'($urandom_range(0, 3));
				if (m == MODE_ALLOC)
					alloc_fresh(SIZE_W'($urandom));
				else
					drive_req(m, SIZE_W'($urandom), CID_W'($urandom));
			end else if (open_cids.size() == 0 || (r < 52 && open_cids.size() < 24)) begin
				k = $urandom_range(0, 99);
				if (k < 75)
					sz = SIZE_W'(4 * $urandom_range(1, (q > 16) ? q / 16 : 1));
				else if (k < 93)
					sz = SIZE_W'(4 * $urandom_range(1, q));
				else if (k < 97)
					sz = SIZE_W'(4 * q);
				else
					sz = SIZE_W'(4 * q + 4);
				alloc_fresh(sz);
			end else if ($urandom_range(0, 2) == 0) begin
				cancel_front();
			end else begin
				k  = $urandom_range(0, open_cids.size() - 1);
				id = open_cids[k];
				m  = mode_t'($urandom_range(1, 3));
				if (m == MODE_CANCEL) begin
					open_cids.delete(k);
					cid_open[id] = 1'b0;
				end
				drive_req(m, SIZE_W'($urandom), id);
			end
		end
	endtask

	initial begin : stimulus
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// size checks and unknown cids at the reset capacity
		drive_req(MODE_ALLOC, SIZE_W'(0), CID_W'(0));
		drive_req(MODE_ALLOC, SIZE_W'(6), CID_W'(0));
		drive_req(MODE_ALLOC, SIZE_W'(65540), CID_W'(0));
		drive_req(MODE_ALLOC, '1, '1);
		drive_req(MODE_SUBMIT, SIZE_W'(0), '1);
		drive_req(MODE_COMPLETE, '1, CID_W'(0));
		drive_req(MODE_CANCEL, SIZE_W'(0), CID_W'(1));
		// fill, fail on the wrap padding, reclaim in order
		drive_req(MODE_ALLOC, SIZE_W'(4), CID_W'(0));
		drive_req(MODE_ALLOC, SIZE_W'(60000), CID_W'(1));
		drive_req(MODE_ALLOC, SIZE_W'(8000), CID_W'(2));
		drive_req(MODE_SUBMIT, SIZE_W'(0), CID_W'(0));
		drive_req(MODE_COMPLETE, SIZE_W'(0), CID_W'(0));
		drive_req(MODE_CANCEL, SIZE_W'(0), CID_W'(1));
		// wrap to offset 0, then an exact fit that puts the tail back at 0
		drive_req(MODE_ALLOC, SIZE_W'(8000), CID_W'(2));
		drive_req(MODE_CANCEL, SIZE_W'(0), CID_W'(2));
		drive_req(MODE_ALLOC, SIZE_W'(57536), CID_W'(3));
		// stale cid marks a freed slot
		drive_req(MODE_SUBMIT, SIZE_W'(0), CID_W'(0));
		drive_req(MODE_ALLOC, SIZE_W'(65536), '1);
		drive_req(MODE_CANCEL, SIZE_W'(0), CID_W'(3));
		drive_req(MODE_ALLOC, SIZE_W'(65536), '1);
		drive_req(MODE_COMPLETE, SIZE_W'(0), '1);
		drive_req(MODE_SUBMIT, SIZE_W'(0), '1);

		random_phase(180, 1'b0);
		set_cap(1048576);
		random_phase(180, 1'b1);
		// capacity drops under the bytes still held
		set_cap(4);
		random_phase(180, 1'b0);
		drain_open();

		// run the order buffer past full with the smallest grants
		set_cap(1048576);
		for (i = 0; i < 270; i++)
			alloc_fresh(SIZE_W'(4));
		drain_open();

		set_cap(1002);
		random_phase(180, 1'b0);
		set_cap(1048575);
		random_phase(180, 1'b0);
		drain_open();
		set_cap(256);
		random_phase(180, 1'b0);
		set_cap($urandom_range(4, 1048576));
		random_phase(180, 1'b0);
		drain_open();

		settle();
		if (fails == 0)
			$display("ring_send_buffer_allocator: match");
		else
			$display("ring_send_buffer_allocator: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rsba_pkg.sv
hdl/rsba_ram.sv
hdl/rsba_core.sv
hdl/ring_send_buffer_allocator.sv
hdl/rsba_checker.sv
bench/rsba_grant_check.sv
bench/tb_ring_send_buffer_allocator.sv
